[rtl/core/tun_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_pkg
// Widths, payload types and constants for the triangle unit normal core.
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int COORD_W     = 24;   // Q12.12 vertex coordinate
    localparam int EDGE_W      = 25;   // Q13.12 edge component
    localparam int CROSS_W     = 50;   // cross product component
    localparam int MAG_W       = 49;   // magnitude of a cross component
    localparam int NORM_W      = 30;   // magnitude after the range shift
    localparam int SHIFT_W     = 5;
    localparam int SQ_W        = 2 * NORM_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int QUO_W       = 33;   // floor(2^32 m^2 / s), at most 2^32
    localparam int ROOT_W      = 17;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int OUT_W       = 16;
    localparam int DIV_STAGES  = QUO_W;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int FRONT_STAGES = 7;

    localparam logic [ROOT_W-1:0] OUT_MAX = ROOT_W'(32767);

    typedef struct packed {
        logic signed [COORD_W-1:0] v0_x;
        logic signed [COORD_W-1:0] v0_y;
        logic signed [COORD_W-1:0] v0_z;
        logic signed [COORD_W-1:0] v1_x;
        logic signed [COORD_W-1:0] v1_y;
        logic signed [COORD_W-1:0] v1_z;
        logic signed [COORD_W-1:0] v2_x;
        logic signed [COORD_W-1:0] v2_y;
        logic signed [COORD_W-1:0] v2_z;
    } t_tri_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    degenerate;
    } t_norm_out;

    // per-item flags that ride along the arithmetic
    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } t_side;

endpackage

[rtl/core/tun_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface tun_stream_if #(
    parameter type T_DATA = logic
);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/triangle_unit_normal_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_unit_normal_core
// Unit face normal of a triangle: edges, cross product, normalization to
// signed Q1.15 with rounding, saturation and a degenerate flag.
//
//   port     dir   word                              handshake
//   i_tri    in    nine Q12.12 vertex coordinates    valid / ready
//   o_norm   out   three Q1.15 components, flag      valid / ready
//
// One triangle per cycle unless the output stalls; 7 front stages (edges,
// products, cross, magnitudes, range shift, squares, sum), 33 divider
// stages (one quotient bit each), 17 square root stages, 1 output stage.
// The divider chain sets the depth.
// Synchronous active-low reset empties the pipeline.
// The whole pipeline advances whenever the output register is empty or
// its word is taken; a stall holds every stage in place.
// ----------------------------------------------------------------------------
module triangle_unit_normal_core
    import tun_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    tun_stream_if.sink    i_tri,
    tun_stream_if.source  o_norm
);

    logic                  en;
    logic                  f_vld, d_vld, s_vld;
    t_side                 f_side, d_side;
    logic [2:0][SQ_W-1:0]  f_sq;
    logic [SUM_W-1:0]      f_sum;
    logic [2:0][QUO_W-1:0] d_quo;
    t_norm_out             s_data;

    assign en          = !s_vld || o_norm.ready;
    assign i_tri.ready = en;

    tun_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_tri.valid),
        .i_tri   (i_tri.data),
        .o_vld   (f_vld),
        .o_side  (f_side),
        .o_sq    (f_sq),
        .o_sum   (f_sum)
    );

    tun_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_side  (f_side),
        .i_sq    (f_sq),
        .i_sum   (f_sum),
        .o_vld   (d_vld),
        .o_side  (d_side),
        .o_quo   (d_quo)
    );

    tun_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (d_vld),
        .i_side  (d_side),
        .i_quo   (d_quo),
        .o_vld   (s_vld),
        .o_data  (s_data)
    );

    assign o_norm.valid = s_vld;
    assign o_norm.data  = s_data;

endmodule

[rtl/core/tun_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_front
// Edges, cross product, magnitudes, range shift, squares and their sum.
// Seven register stages.
// ----------------------------------------------------------------------------
module tun_front
    import tun_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  t_tri_in                i_tri,
    output logic                   o_vld,
    output t_side                  o_side,
    output logic [2:0][SQ_W-1:0]   o_sq,
    output logic [SUM_W-1:0]       o_sum
);

    logic [FRONT_STAGES-1:0] r_vld;

    logic signed [2:0][EDGE_W-1:0]  r_e0, r_e1;
    logic signed [5:0][CROSS_W-1:0] r_p;
    logic signed [2:0][CROSS_W-1:0] r_n;
    logic [2:0][MAG_W-1:0]          r_a;
    logic [2:0][NORM_W-1:0]         r_m;
    logic [2:0][SQ_W-1:0]           r_sq, r_sq2;
    logic [SUM_W-1:0]               r_sum;
    t_side                          r_side_d, r_side_e, r_side_f, r_side_g;

    logic [MAG_W-1:0]   n_or;
    logic [SHIFT_W-1:0] n_k;

    always_comb begin
        n_or = r_a[0] | r_a[1] | r_a[2];
        n_k  = '0;
        // bit length of the largest magnitude equals that of the or of all three
        for (int b = NORM_W; b < MAG_W; b++) begin
            if (n_or[b]) begin
                n_k = SHIFT_W'(b - NORM_W + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[FRONT_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e0[0] <= EDGE_W'(i_tri.v1_x) - EDGE_W'(i_tri.v0_x);
            r_e0[1] <= EDGE_W'(i_tri.v1_y) - EDGE_W'(i_tri.v0_y);
            r_e0[2] <= EDGE_W'(i_tri.v1_z) - EDGE_W'(i_tri.v0_z);
            r_e1[0] <= EDGE_W'(i_tri.v2_x) - EDGE_W'(i_tri.v0_x);
            r_e1[1] <= EDGE_W'(i_tri.v2_y) - EDGE_W'(i_tri.v0_y);
            r_e1[2] <= EDGE_W'(i_tri.v2_z) - EDGE_W'(i_tri.v0_z);

            // element selects are unsigned, so the edges are re-signed here
            r_p[0] <= CROSS_W'($signed(r_e0[1])) * CROSS_W'($signed(r_e1[2]));
            r_p[1] <= CROSS_W'($signed(r_e0[2])) * CROSS_W'($signed(r_e1[1]));
            r_p[2] <= CROSS_W'($signed(r_e0[2])) * CROSS_W'($signed(r_e1[0]));
            r_p[3] <= CROSS_W'($signed(r_e0[0])) * CROSS_W'($signed(r_e1[2]));
            r_p[4] <= CROSS_W'($signed(r_e0[0])) * CROSS_W'($signed(r_e1[1]));
            r_p[5] <= CROSS_W'($signed(r_e0[1])) * CROSS_W'($signed(r_e1[0]));

            r_n[0] <= r_p[0] - r_p[1];
            r_n[1] <= r_p[2] - r_p[3];
            r_n[2] <= r_p[4] - r_p[5];

            for (int l = 0; l < 3; l++) begin
                r_a[l]          <= r_n[l][CROSS_W-1] ? MAG_W'(-r_n[l]) : MAG_W'(r_n[l]);
                r_side_d.neg[l] <= r_n[l][CROSS_W-1];
            end
            r_side_d.degen <= (r_n[0] == '0) && (r_n[1] == '0) && (r_n[2] == '0);

            for (int l = 0; l < 3; l++) begin
                r_m[l] <= NORM_W'(r_a[l] >> n_k);
            end
            r_side_e <= r_side_d;

            for (int l = 0; l < 3; l++) begin
                r_sq[l] <= SQ_W'(r_m[l]) * SQ_W'(r_m[l]);
            end
            r_side_f <= r_side_e;

            r_sum    <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            r_sq2    <= r_sq;
            r_side_g <= r_side_f;
        end
    end

    assign o_vld  = r_vld[FRONT_STAGES-1];
    assign o_side = r_side_g;
    assign o_sq   = r_sq2;
    assign o_sum  = r_sum;

endmodule

[rtl/core/tun_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_div
// Restoring divider, one quotient bit per stage, three lanes sharing one
// divisor: quotient = floor(2^32 * sq / sum).
// ----------------------------------------------------------------------------
module tun_div
    import tun_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  t_side                   i_side,
    input  logic [2:0][SQ_W-1:0]    i_sq,
    input  logic [SUM_W-1:0]        i_sum,
    output logic                    o_vld,
    output t_side                   o_side,
    output logic [2:0][QUO_W-1:0]   o_quo
);

    logic                    r_vld  [DIV_STAGES];
    t_side                   r_side [DIV_STAGES];
    logic [SUM_W-1:0]        r_div  [DIV_STAGES];
    logic [2:0][SUM_W-1:0]   r_rem  [DIV_STAGES];
    logic [2:0][QUO_W-1:0]   r_quo  [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
        logic                  n_vld;
        t_side                 n_side;
        logic [SUM_W-1:0]      n_div;
        logic [2:0][SUM_W:0]   n_part;
        logic [2:0][QUO_W-1:0] n_prev;
        logic [2:0][SUM_W-1:0] n_rem;
        logic [2:0][QUO_W-1:0] n_quo;
        logic [2:0]            n_bit;

        if (j == 0) begin : g_first
            always_comb begin
                n_vld  = i_vld;
                n_side = i_side;
                n_div  = i_sum;
                for (int l = 0; l < 3; l++) begin
                    n_part[l] = (SUM_W+1)'(i_sq[l]);
                    n_prev[l] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                n_vld  = r_vld[j-1];
                n_side = r_side[j-1];
                n_div  = r_div[j-1];
                for (int l = 0; l < 3; l++) begin
                    n_part[l] = {r_rem[j-1][l], 1'b0};
                    n_prev[l] = r_quo[j-1][l];
                end
            end
        end

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                n_bit[l] = n_part[l] >= {1'b0, n_div};
                n_rem[l] = n_bit[l] ? SUM_W'(n_part[l] - {1'b0, n_div})
                                    : n_part[l][SUM_W-1:0];
                n_quo[l] = {n_prev[l][QUO_W-2:0], n_bit[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= n_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[j] <= n_side;
                r_div[j]  <= n_div;
                r_rem[j]  <= n_rem;
                r_quo[j]  <= n_quo;
            end
        end
    end

    assign o_vld  = r_vld[DIV_STAGES-1];
    assign o_side = r_side[DIV_STAGES-1];
    assign o_quo  = r_quo[DIV_STAGES-1];

endmodule

[rtl/core/tun_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_sqrt
// Integer square root, one result bit per stage, then rounding to Q1.15,
// saturation, sign and the degenerate case in the output register.
// ----------------------------------------------------------------------------
module tun_sqrt
    import tun_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  t_side                  i_side,
    input  logic [2:0][QUO_W-1:0]  i_quo,
    output logic                   o_vld,
    output t_norm_out              o_data
);

    logic                  r_vld  [SQRT_STAGES];
    t_side                 r_side [SQRT_STAGES];
    logic [2:0][RAD_W-1:0] r_rad  [SQRT_STAGES];
    logic [2:0][RAD_W-1:0] r_res  [SQRT_STAGES];

    logic      r_out_vld;
    t_norm_out r_out;

    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_STAGES - 1 - j));

        logic                  n_vld;
        t_side                 n_side;
        logic [2:0][RAD_W-1:0] n_rad_in, n_res_in, n_rad, n_res, n_trial;

        if (j == 0) begin : g_first
            always_comb begin
                n_vld  = i_vld;
                n_side = i_side;
                for (int l = 0; l < 3; l++) begin
                    n_rad_in[l] = RAD_W'(i_quo[l]);
                    n_res_in[l] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                n_vld    = r_vld[j-1];
                n_side   = r_side[j-1];
                n_rad_in = r_rad[j-1];
                n_res_in = r_res[j-1];
            end
        end

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                n_trial[l] = n_res_in[l] + BIT;
                if (n_rad_in[l] >= n_trial[l]) begin
                    n_rad[l] = n_rad_in[l] - n_trial[l];
                    n_res[l] = (n_res_in[l] >> 1) + BIT;
                end else begin
                    n_rad[l] = n_rad_in[l];
                    n_res[l] = n_res_in[l] >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= n_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[j] <= n_side;
                r_rad[j]  <= n_rad;
                r_res[j]  <= n_res;
            end
        end
    end

    // largest q with 2q-1 <= root is (root+1)/2
    logic [2:0][ROOT_W:0]     n_inc;
    logic [2:0][ROOT_W-1:0]   n_q;
    logic [2:0][OUT_W-1:0]    n_c;
    t_side                    n_last;

    always_comb begin
        n_last = r_side[SQRT_STAGES-1];
        for (int l = 0; l < 3; l++) begin
            n_inc[l] = (ROOT_W+1)'(r_res[SQRT_STAGES-1][l][ROOT_W-1:0]) + (ROOT_W+1)'(1);
            n_q[l]   = n_inc[l][ROOT_W:1];
            if (n_q[l] > OUT_MAX) begin
                n_q[l] = OUT_MAX;
            end
            if (n_last.degen) begin
                n_c[l] = '0;
            end else if (n_last.neg[l]) begin
                n_c[l] = OUT_W'(-n_q[l]);
            end else begin
                n_c[l] = OUT_W'(n_q[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[SQRT_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.normal_x   <= n_c[0];
            r_out.normal_y   <= n_c[1];
            r_out.normal_z   <= n_c[2];
            r_out.degenerate <= n_last.degen;
        end
    end

    assign o_vld  = r_out_vld;
    assign o_data = r_out;

endmodule
